FILE: rtl/core/rpa_pkg.sv
// Shared constants, types and helpers for the record pool allocator.
// No dependencies; every other file of the block imports this package.
package rpa_pkg;

    localparam int CAPACITY    = 256;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int LINK_W      = 9;
    localparam int CNT_W       = 9;
    localparam int CLASS_W     = 8;
    localparam int CLASS_CMP_W = 5;
    localparam int KIND_W      = 2;
    localparam int STAT_W      = 2;
    localparam int CFG_ADDR_W  = 1;
    localparam int CFG_DATA_W  = 9;

    localparam logic [LINK_W-1:0] NONE = LINK_W'(CAPACITY);

    // operation kinds
    localparam logic [KIND_W-1:0] KIND_RESET = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FREE  = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FAULTED = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BAD     = 2'd2;
    localparam logic [STAT_W-1:0] STAT_REFUSED = 2'd3;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_RESERVED_CLASS = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RESERVE_COUNT  = 1'd1;

    typedef struct packed {
        logic load_item;
        logic sweep_wr;
        logic sweep_end;
        logic alloc_pop;
        logic alloc_link;
        logic free_rd;
        logic free_unlink;
        logic free_push;
        logic set_fault;
    } ctl_cmd_t;

    typedef struct packed {
        logic refuse;
        logic handle_bad;
        logic fault;
        logic live;
        logic sweep_last;
    } dp_stat_t;

    typedef struct packed {
        logic [CNT_W-1:0]  free_total;
        logic [LINK_W-1:0] head;
        logic [LINK_W-1:0] tail;
        logic [LINK_W-1:0] alloc_slot;
    } dp_view_t;

    typedef struct packed {
        logic              load_out;
        logic [STAT_W-1:0] status;
        logic              slot_ok;
    } ctl_out_t;

    function automatic logic in_pool(input logic [LINK_W-1:0] v);
        return v < LINK_W'(CAPACITY);
    endfunction

    // any link that is not a slot index reads as none
    function automatic logic [LINK_W-1:0] norm_link(input logic [LINK_W-1:0] v);
        return in_pool(v) ? v : NONE;
    endfunction

endpackage

FILE: rtl/core/rpa_datapath.sv
// Datapath: link memories, list heads, counters and configuration registers.
// Driven by commands from rpa_ctl; uses rpa_pkg.
module rpa_datapath
    import rpa_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic [CLASS_W-1:0]     in_class,
    input  logic [LINK_W-1:0]      in_handle,
    input  ctl_cmd_t               cmd,
    output dp_stat_t               stat,
    output dp_view_t               view
);

    logic [CLASS_CMP_W-1:0] reserved_class_reg;
    logic [CNT_W-1:0]       reserve_count_reg;
    logic [CLASS_W-1:0]     class_reg;
    logic [LINK_W-1:0]      handle_reg;
    logic [LINK_W-1:0]      head_reg;
    logic [LINK_W-1:0]      tail_reg;
    logic [LINK_W-1:0]      free_head_reg;
    logic [CNT_W-1:0]       free_total_reg;
    logic                   fault_reg;
    logic [LINK_W-1:0]      alloc_slot_reg;
    logic [IDX_W-1:0]       iter_reg;

    logic [LINK_W-1:0] next_mem [CAPACITY];
    logic [LINK_W-1:0] prev_mem [CAPACITY];
    logic              live_mem [CAPACITY];

    logic [LINK_W-1:0] next_rd_reg;
    logic [LINK_W-1:0] prev_rd_reg;
    logic              live_rd_reg;

    logic [IDX_W-1:0]  rd_idx;
    logic              next_we;
    logic [IDX_W-1:0]  next_wa;
    logic [LINK_W-1:0] next_wd;
    logic              prev_we;
    logic [IDX_W-1:0]  prev_wa;
    logic [LINK_W-1:0] prev_wd;
    logic              live_we;
    logic [IDX_W-1:0]  live_wa;
    logic              live_wd;
    logic [IDX_W-1:0]  handle_idx;
    logic              sweep_last;

    assign handle_idx = handle_reg[IDX_W-1:0];
    assign sweep_last = (iter_reg == IDX_W'(CAPACITY - 1));
    assign rd_idx     = cmd.free_rd ? handle_idx : free_head_reg[IDX_W-1:0];

    // write port selection; the controller never issues two writers at once
    always_comb begin
        next_we = 1'b0;
        next_wa = iter_reg;
        next_wd = NONE;
        prev_we = 1'b0;
        prev_wa = iter_reg;
        prev_wd = '0;
        live_we = 1'b0;
        live_wa = iter_reg;
        live_wd = 1'b0;
        if (cmd.sweep_wr) begin
            next_we = 1'b1;
            next_wd = sweep_last ? NONE : LINK_W'(iter_reg) + LINK_W'(1);
            prev_we = 1'b1;
            live_we = 1'b1;
        end
        if (cmd.alloc_pop) begin
            next_we = 1'b1;
            next_wa = free_head_reg[IDX_W-1:0];
            next_wd = NONE;
            prev_we = 1'b1;
            prev_wa = free_head_reg[IDX_W-1:0];
            prev_wd = tail_reg;
            live_we = 1'b1;
            live_wa = free_head_reg[IDX_W-1:0];
            live_wd = 1'b1;
        end
        if (cmd.alloc_link && in_pool(tail_reg)) begin
            next_we = 1'b1;
            next_wa = tail_reg[IDX_W-1:0];
            next_wd = alloc_slot_reg;
        end
        if (cmd.free_unlink) begin
            if (in_pool(prev_rd_reg)) begin
                next_we = 1'b1;
                next_wa = prev_rd_reg[IDX_W-1:0];
                next_wd = norm_link(next_rd_reg);
            end
            if (in_pool(next_rd_reg)) begin
                prev_we = 1'b1;
                prev_wa = next_rd_reg[IDX_W-1:0];
                prev_wd = norm_link(prev_rd_reg);
            end
            live_we = 1'b1;
            live_wa = handle_idx;
            live_wd = 1'b0;
        end
        if (cmd.free_push) begin
            next_we = 1'b1;
            next_wa = handle_idx;
            next_wd = free_head_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (next_we) begin
            next_mem[next_wa] <= next_wd;
        end
        if (prev_we) begin
            prev_mem[prev_wa] <= prev_wd;
        end
        if (live_we) begin
            live_mem[live_wa] <= live_wd;
        end
        next_rd_reg <= next_mem[rd_idx];
        prev_rd_reg <= prev_mem[rd_idx];
        live_rd_reg <= live_mem[rd_idx];
    end

    // item fields, sweep counter and allocated slot: payload, no reset
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            class_reg  <= in_class;
            handle_reg <= in_handle;
            iter_reg   <= '0;
        end else if (cmd.sweep_wr) begin
            iter_reg <= iter_reg + IDX_W'(1);
        end
        if (cmd.alloc_pop) begin
            alloc_slot_reg <= free_head_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reserved_class_reg <= '0;
            reserve_count_reg  <= '0;
            head_reg           <= NONE;
            tail_reg           <= NONE;
            free_head_reg      <= NONE;
            free_total_reg     <= '0;
            fault_reg          <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_RESERVED_CLASS: reserved_class_reg <= cfg_wdata[CLASS_CMP_W-1:0];
                    REG_RESERVE_COUNT:  reserve_count_reg  <= cfg_wdata[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.sweep_end) begin
                head_reg       <= NONE;
                tail_reg       <= NONE;
                free_head_reg  <= '0;
                free_total_reg <= CNT_W'(CAPACITY);
            end
            if (cmd.alloc_pop) begin
                free_head_reg  <= norm_link(next_rd_reg);
                free_total_reg <= free_total_reg - CNT_W'(1);
            end
            if (cmd.alloc_link) begin
                if (!in_pool(tail_reg)) begin
                    head_reg <= alloc_slot_reg;
                end
                tail_reg <= alloc_slot_reg;
            end
            if (cmd.free_unlink) begin
                if (!in_pool(prev_rd_reg)) begin
                    head_reg <= norm_link(next_rd_reg);
                end
                if (!in_pool(next_rd_reg)) begin
                    tail_reg <= norm_link(prev_rd_reg);
                end
                free_total_reg <= free_total_reg + CNT_W'(1);
            end
            if (cmd.free_push) begin
                free_head_reg <= handle_reg;
            end
            if (cmd.set_fault) begin
                fault_reg <= 1'b1;
            end
        end
    end

    assign stat.refuse = ((class_reg[CLASS_CMP_W-1:0] == reserved_class_reg)
                          && (free_total_reg < reserve_count_reg))
                         || !in_pool(free_head_reg);
    assign stat.handle_bad = !in_pool(handle_reg);
    assign stat.fault      = fault_reg;
    assign stat.live       = live_rd_reg;
    assign stat.sweep_last = sweep_last;

    assign view.free_total = free_total_reg;
    assign view.head       = head_reg;
    assign view.tail       = tail_reg;
    assign view.alloc_slot = alloc_slot_reg;

endmodule

FILE: rtl/core/rpa_ctl.sv
// Controller: sequences reset sweep, allocate and free over the datapath.
// Uses rpa_pkg; talks to rpa_datapath through ctl_cmd_t / dp_stat_t.
module rpa_ctl
    import rpa_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic [KIND_W-1:0] in_kind,
    output logic              in_ready,
    input  logic              out_free,
    input  dp_stat_t          stat,
    output ctl_cmd_t          cmd,
    output ctl_out_t          oc
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SWEEP  = 4'd1;
    localparam logic [3:0] ST_ALLOC  = 4'd2;
    localparam logic [3:0] ST_ALLOC2 = 4'd3;
    localparam logic [3:0] ST_ALLOC3 = 4'd4;
    localparam logic [3:0] ST_FREE   = 4'd5;
    localparam logic [3:0] ST_FREE2  = 4'd6;
    localparam logic [3:0] ST_FREE3  = 4'd7;
    localparam logic [3:0] ST_DONE   = 4'd8;

    logic [3:0]        state_reg;
    logic [3:0]        state_next;
    logic [STAT_W-1:0] status_reg;
    logic [STAT_W-1:0] status_next;
    logic              slot_ok_reg;
    logic              slot_ok_next;
    logic              accept;

    assign in_ready = (state_reg == ST_IDLE) || ((state_reg == ST_DONE) && out_free);
    assign accept   = in_valid && in_ready;

    always_comb begin
        state_next   = state_reg;
        status_next  = status_reg;
        slot_ok_next = slot_ok_reg;
        cmd          = '0;
        oc.load_out  = 1'b0;
        oc.status    = status_reg;
        oc.slot_ok   = slot_ok_reg;

        case (state_reg)
            ST_IDLE: ;
            ST_SWEEP: begin
                cmd.sweep_wr = 1'b1;
                if (stat.sweep_last) begin
                    cmd.sweep_end = 1'b1;
                    state_next    = ST_DONE;
                end
            end
            ST_ALLOC: begin
                // the free head entry is read every cycle
                if (stat.refuse) begin
                    status_next = STAT_REFUSED;
                    state_next  = ST_DONE;
                end else begin
                    state_next = ST_ALLOC2;
                end
            end
            ST_ALLOC2: begin
                cmd.alloc_pop = 1'b1;
                state_next    = ST_ALLOC3;
            end
            ST_ALLOC3: begin
                cmd.alloc_link = 1'b1;
                slot_ok_next   = 1'b1;
                state_next     = ST_DONE;
            end
            ST_FREE: begin
                if (stat.fault) begin
                    status_next = STAT_FAULTED;
                    state_next  = ST_DONE;
                end else if (stat.handle_bad) begin
                    cmd.set_fault = 1'b1;
                    status_next   = STAT_BAD;
                    state_next    = ST_DONE;
                end else begin
                    cmd.free_rd = 1'b1;
                    state_next  = ST_FREE2;
                end
            end
            ST_FREE2: begin
                if (!stat.live) begin
                    cmd.set_fault = 1'b1;
                    status_next   = STAT_BAD;
                    state_next    = ST_DONE;
                end else begin
                    cmd.free_unlink = 1'b1;
                    state_next      = ST_FREE3;
                end
            end
            ST_FREE3: begin
                cmd.free_push = 1'b1;
                state_next    = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    oc.load_out = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // a new transaction may start in the same cycle the result leaves
        if (accept) begin
            cmd.load_item = 1'b1;
            status_next   = STAT_OK;
            slot_ok_next  = 1'b0;
            case (in_kind)
                KIND_RESET: state_next = ST_SWEEP;
                KIND_ALLOC: state_next = ST_ALLOC;
                KIND_FREE:  state_next = ST_FREE;
                default:    state_next = ST_DONE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            status_reg  <= STAT_OK;
            slot_ok_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            status_reg  <= status_next;
            slot_ok_reg <= slot_ok_next;
        end
    end

endmodule

FILE: rtl/core/record_pool_allocator.sv
// Record pool allocator top level: stream ports, output register, assertions.
// A request is accepted only in idle or as the result leaves, so only one request
// is in flight at a time; the link memories have one write port each, so
// dependent read/write steps set the allocate/free pace.
// aresetn (sync, active low) empties both lists and clears the fault flag.
module record_pool_allocator
    import rpa_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,  // record_class[7:0], handle[16:8], zero pad
    input  logic [KIND_W-1:0]     s_tuser,  // kind[1:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [39:0]           m_tdata,  // slot[8:0], free_slots[17:9],
                                            // active_head[26:18], active_tail[35:27], pad
    output logic [STAT_W-1:0]     m_tuser,  // status[1:0]
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    ctl_cmd_t ctl_cmd;
    ctl_out_t ctl_oc;
    dp_stat_t dp_stat;
    dp_view_t dp_view;

    logic              m_tvalid_reg;
    logic [STAT_W-1:0] out_status_reg;
    logic [LINK_W-1:0] out_slot_reg;
    logic [CNT_W-1:0]  out_free_reg;
    logic [LINK_W-1:0] out_head_reg;
    logic [LINK_W-1:0] out_tail_reg;
    logic              out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    rpa_ctl u_ctl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_kind  (s_tuser),
        .in_ready (s_tready),
        .out_free (out_free),
        .stat     (dp_stat),
        .cmd      (ctl_cmd),
        .oc       (ctl_oc)
    );

    rpa_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_class  (s_tdata[7:0]),
        .in_handle (s_tdata[16:8]),
        .cmd       (ctl_cmd),
        .stat      (dp_stat),
        .view      (dp_view)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctl_oc.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl_oc.load_out) begin
            out_status_reg <= ctl_oc.status;
            out_slot_reg   <= ctl_oc.slot_ok ? dp_view.alloc_slot : NONE;
            out_free_reg   <= dp_view.free_total;
            out_head_reg   <= dp_view.head;
            out_tail_reg   <= dp_view.tail;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {4'd0, out_tail_reg, out_head_reg, out_free_reg, out_slot_reg};

`ifndef SYNTHESIS
    // a result is never loaded over one the sink has not taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctl_oc.load_out |-> (!m_tvalid_reg || m_tready))
        else $error("result register overwritten while stalled");

    // a slot is reported only with an ok status
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[8:0] != NONE)) |-> (m_tuser == STAT_OK))
        else $error("slot reported on a failed transaction");

    // a freshly shown result was loaded by the controller in the cycle before
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(ctl_oc.load_out))
        else $error("result valid without a load");
`endif

endmodule

FILE: dv/record_pool_allocator_test.sv
// Self-checking testbench for record_pool_allocator: a shadow copy of the slot pool
// predicts every reply while random bursts and stalls exercise both stream ports.
// Depends on rpa_pkg and the record_pool_allocator top level.
module record_pool_allocator_test;
    import rpa_pkg::*;

    // kind 3 has no name in the package; the block answers it with an ok reply and changes nothing
    localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;
    localparam int IDLE_LIMIT  = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AFTER  = 300;

    typedef struct {
        logic [STAT_W-1:0] status;
        logic [LINK_W-1:0] slot;
        logic [CNT_W-1:0]  free_slots;
        logic [LINK_W-1:0] head;
        logic [LINK_W-1:0] tail;
    } pool_reply_t;

    class pool_tracker;
        bit [LINK_W-1:0]      nxt [CAPACITY];
        bit [LINK_W-1:0]      prv [CAPACITY];
        bit                   live [CAPACITY];
        bit [LINK_W-1:0]      act_head;
        bit [LINK_W-1:0]      act_tail;
        bit [LINK_W-1:0]      free_top;
        bit [CNT_W-1:0]       free_cnt;
        bit                   faulted;
        bit [CLASS_CMP_W-1:0] rsv_class;
        bit [CNT_W-1:0]       rsv_count;
        pool_reply_t          reply_q[$];
        int                   errors;

        function new();
            for (int i = 0; i < CAPACITY; i++) begin
                nxt[i]  = '0;
                prv[i]  = '0;
                live[i] = 1'b0;
            end
            act_head  = NONE;
            act_tail  = NONE;
            free_top  = NONE;
            free_cnt  = '0;
            faulted   = 1'b0;
            rsv_class = '0;
            rsv_count = '0;
            errors    = 0;
        endfunction

        function bit in_range(input bit [LINK_W-1:0] v);
            return v < CAPACITY;
        endfunction

        function bit [LINK_W-1:0] as_link(input bit [LINK_W-1:0] v);
            return in_range(v) ? v : NONE;
        endfunction

        function void set_reg(input logic [CFG_ADDR_W-1:0] addr,
                              input logic [CFG_DATA_W-1:0] data);
            if (addr == REG_RESERVED_CLASS)
                rsv_class = data[CLASS_CMP_W-1:0];
            else
                rsv_count = data[CNT_W-1:0];
        endfunction

        // random live slot, favoring the list ends; NONE when nothing is live
        function bit [LINK_W-1:0] pick_live();
            int start;
            int k;
            if (in_range(act_head) && $urandom_range(4) == 0)
                return $urandom_range(1) ? act_head : act_tail;
            start = $urandom_range(CAPACITY - 1);
            for (k = 0; k < CAPACITY; k++)
                if (live[(start + k) % CAPACITY])
                    return LINK_W'((start + k) % CAPACITY);
            return NONE;
        endfunction

        function int pending();
            return reply_q.size();
        endfunction

        function void note_request(input logic [KIND_W-1:0]  kind,
                                   input logic [CLASS_W-1:0] cls,
                                   input logic [LINK_W-1:0]  handle);
            pool_reply_t     r;
            bit [LINK_W-1:0] s;
            bit [LINK_W-1:0] p;
            bit [LINK_W-1:0] n;
            r.status = STAT_OK;
            r.slot   = NONE;
            case (kind)
                KIND_RESET: begin
                    for (int i = 0; i < CAPACITY; i++) begin
                        nxt[i]  = (i + 1 < CAPACITY) ? LINK_W'(i + 1) : NONE;
                        prv[i]  = '0;
                        live[i] = 1'b0;
                    end
                    act_head = NONE;
                    act_tail = NONE;
                    free_top = '0;
                    free_cnt = CNT_W'(CAPACITY);
                end
                KIND_ALLOC: begin
                    if (cls[CLASS_CMP_W-1:0] == rsv_class && free_cnt < rsv_count) begin
                        r.status = STAT_REFUSED;
                    end else if (!in_range(free_top)) begin
                        r.status = STAT_REFUSED;
                    end else begin
                        s = free_top;
                        free_top = as_link(nxt[s[IDX_W-1:0]]);
                        free_cnt = free_cnt - 1'b1;
                        live[s[IDX_W-1:0]] = 1'b1;
                        prv[s[IDX_W-1:0]]  = act_tail;
                        nxt[s[IDX_W-1:0]]  = NONE;
                        if (!in_range(act_tail))
                            act_head = s;
                        else
                            nxt[act_tail[IDX_W-1:0]] = s;
                        act_tail = s;
                        r.slot = s;
                    end
                end
                KIND_FREE: begin
                    if (faulted) begin
                        r.status = STAT_FAULTED;
                    end else if (!in_range(handle) || !live[handle[IDX_W-1:0]]) begin
                        faulted  = 1'b1;
                        r.status = STAT_BAD;
                    end else begin
                        p = prv[handle[IDX_W-1:0]];
                        n = nxt[handle[IDX_W-1:0]];
                        if (!in_range(p))
                            act_head = as_link(n);
                        else
                            nxt[p[IDX_W-1:0]] = as_link(n);
                        if (in_range(n))
                            prv[n[IDX_W-1:0]] = as_link(p);
                        else
                            act_tail = as_link(p);
                        free_cnt = free_cnt + 1'b1;
                        nxt[handle[IDX_W-1:0]]  = free_top;
                        free_top = handle;
                        live[handle[IDX_W-1:0]] = 1'b0;
                    end
                end
                default: ;
            endcase
            r.free_slots = free_cnt;
            r.head       = act_head;
            r.tail       = act_tail;
            reply_q.push_back(r);
        endfunction

        function void compare_field(input string name, input int want, input int got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_reply(input logic [STAT_W-1:0] status, input logic [39:0] data);
            pool_reply_t e;
            if (reply_q.size() == 0) begin
                $error("unexpected reply transaction: status %0d data %h", status, data);
                errors++;
                return;
            end
            e = reply_q.pop_front();
            compare_field("status", e.status, status);
            compare_field("slot", e.slot, data[8:0]);
            compare_field("free_slots", e.free_slots, data[17:9]);
            compare_field("active_head", e.head, data[26:18]);
            compare_field("active_tail", e.tail, data[35:27]);
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [23:0]           s_tdata;
    logic [KIND_W-1:0]     s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [39:0]           m_tdata;
    logic [STAT_W-1:0]     m_tuser;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    pool_tracker pool = new();
    int          burst_left;
    int          replies;

    always #2 aclk = ~aclk;

    record_pool_allocator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // one request transaction; opens a new burst, after a random gap, when the last one ran out
    task automatic send_item(input logic [KIND_W-1:0]  kind,
                             input logic [CLASS_W-1:0] cls,
                             input logic [LINK_W-1:0]  handle);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(60, 20) : $urandom_range(12, 1);
            gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(6, 1);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {7'b0, handle, cls};
        do @(posedge aclk); while (!s_tready);
        pool.note_request(kind, cls, handle);
    endtask

    // registers change only with the block drained
    task automatic write_regs(input logic [CLASS_CMP_W-1:0] cls, input logic [CNT_W-1:0] cnt);
        s_tvalid <= 1'b0;
        while (pool.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_RESERVED_CLASS;
        cfg_wdata <= CFG_DATA_W'(cls);
        @(posedge aclk);
        cfg_addr  <= REG_RESERVE_COUNT;
        cfg_wdata <= cnt;
        @(posedge aclk);
        cfg_we <= 1'b0;
        pool.set_reg(REG_RESERVED_CLASS, CFG_DATA_W'(cls));
        pool.set_reg(REG_RESERVE_COUNT, cnt);
        burst_left = 0;
    endtask

    // mostly allocs and frees of live slots; ignored kinds do not count toward the total
    task automatic run_phase(input int count, input int alloc_pct, input int reset_pm);
        int               done;
        int               pick;
        logic [CLASS_W-1:0] cls;
        logic [LINK_W-1:0]  h;
        done = 0;
        while (done < count) begin
            pick = $urandom_range(999);
            cls  = ($urandom_range(2) == 0) ? {3'($urandom), pool.rsv_class} : CLASS_W'($urandom);
            h    = pool.pick_live();
            if (pick < reset_pm) begin
                send_item(KIND_RESET, cls, LINK_W'($urandom));
                done++;
            end else if (pick < reset_pm + 25) begin
                send_item(KIND_NOP, cls, LINK_W'($urandom));
            end else if (h == NONE || $urandom_range(99) < alloc_pct) begin
                send_item(KIND_ALLOC, cls, LINK_W'($urandom));
                done++;
            end else begin
                send_item(KIND_FREE, cls, h);
                done++;
            end
        end
    endtask

    initial begin
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= KIND_RESET;
        cfg_we     <= 1'b0;
        cfg_addr   <= REG_RESERVED_CLASS;
        cfg_wdata  <= '0;
        aresetn    <= 1'b0;
        burst_left = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // free list still empty before the first pool reset
        send_item(KIND_ALLOC, 8'h00, 9'd0);
        send_item(KIND_NOP, 8'hFF, 9'h1FF);
        send_item(KIND_RESET, 8'h00, 9'd0);
        send_item(KIND_ALLOC, 8'hFF, 9'd0);
        send_item(KIND_ALLOC, 8'h00, 9'd0);
        send_item(KIND_ALLOC, 8'h1F, 9'd0);
        send_item(KIND_ALLOC, 8'hA5, 9'd0);
        // middle, head, tail, then the last one
        send_item(KIND_FREE, 8'h00, 9'd1);
        send_item(KIND_FREE, 8'h00, 9'd0);
        send_item(KIND_FREE, 8'h00, 9'd3);
        send_item(KIND_FREE, 8'h00, 9'd2);
        send_item(KIND_ALLOC, 8'h40, 9'd0);
        send_item(KIND_NOP, 8'h00, 9'd0);
        send_item(KIND_RESET, 8'hFF, 9'h1FF);

        // reserve of the whole pool: only a completely free pool passes
        write_regs(5'd5, 9'd256);
        send_item(KIND_ALLOC, 8'h05, 9'd0);
        send_item(KIND_ALLOC, 8'h25, 9'd0);
        send_item(KIND_ALLOC, 8'h06, 9'd0);
        send_item(KIND_ALLOC, 8'hE5, 9'd0);

        write_regs(5'd31, 9'd256);
        run_phase(200, 60, 10);
        // pool runs full here
        write_regs(5'd7, 9'd128);
        run_phase(350, 97, 0);
        write_regs(5'd0, 9'd1);
        run_phase(250, 30, 10);
        write_regs(5'd19, 9'd40);
        run_phase(250, 75, 5);
        write_regs(5'd31, 9'd0);
        run_phase(200, 50, 10);

        // sticky fault last: nothing but aresetn clears it
        write_regs(5'd0, 9'd0);
        send_item(KIND_RESET, 8'h00, 9'd0);
        send_item(KIND_ALLOC, 8'h11, 9'd0);
        if ($urandom_range(1))
            send_item(KIND_FREE, 8'h00, LINK_W'($urandom_range(511, CAPACITY)));
        else
            send_item(KIND_FREE, 8'h00, LINK_W'($urandom_range(CAPACITY - 1, 1)));
        send_item(KIND_FREE, 8'h00, 9'd0);
        send_item(KIND_FREE, 8'h00, 9'h1FF);
        send_item(KIND_ALLOC, 8'h80, 9'd0);
        send_item(KIND_RESET, 8'h00, 9'd0);
        send_item(KIND_FREE, 8'h00, 9'd0);
        repeat (60)
            send_item(KIND_W'($urandom), CLASS_W'($urandom), LINK_W'($urandom));

        s_tvalid <= 1'b0;
        while (pool.pending() != 0) @(posedge aclk);
        repeat (CAPACITY + 40) @(posedge aclk);
        if (pool.errors == 0 && pool.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // reply side: rotating stall pattern plus one long hold-off so the block backs up
    initial begin
        int cyc;
        bit held;
        cyc     = 0;
        held    = 1'b0;
        replies = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            cyc++;
            if (m_tvalid && m_tready) begin
                pool.check_reply(m_tuser, m_tdata);
                replies++;
            end
            if (!held && replies == HOLD_AFTER) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            case ((cyc / 97) % 4)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(1));
                2:       m_tready <= (cyc % 4 == 0);
                default: m_tready <= ($urandom_range(7) == 0);
            endcase
        end
    end

    // watchdog: too long without any transaction on either side
    initial begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle = 0;
            else
                idle++;
        end
        $display("FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/rpa_pkg.sv
rtl/core/rpa_datapath.sv
rtl/core/rpa_ctl.sv
rtl/core/record_pool_allocator.sv
dv/record_pool_allocator_test.sv
